// ===== rtl/cdfs_pkg.sv =====
package cdfs_pkg;

	// Default sizes of the stores
	localparam int unsigned IMAGE_DEPTH_DEF = 4096;
	localparam int unsigned MAX_COLORS_DEF  = 8;

	// Fixed-point constants
	localparam logic [16:0] ONE_Q16 = 17'h10000;
	localparam logic [15:0] CEIL_SQ = 16'd65025;

	// Item commands
	localparam logic [1:0] CMD_LOAD_PIXEL = 2'd0;
	localparam logic [1:0] CMD_LOAD_KEY   = 2'd1;
	localparam logic [1:0] CMD_SAMPLE     = 2'd2;

	// Configuration register indexes
	localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
	localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
	localparam logic [2:0] REG_COLOR_COUNT  = 3'd2;
	localparam logic [2:0] REG_START_DIST   = 3'd3;
	localparam logic [2:0] REG_END_DIST     = 3'd4;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [11:0] slot;
		logic [23:0] rgb;
		logic [16:0] u_coord;
		logic [16:0] v_coord;
		logic        point_rejected;
	} in_item_t;

	typedef struct packed {
		logic [16:0] falloff_value;
		logic        sample_done;
	} out_item_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic decode;
		logic xy;
		logic addr;
		logic load_pix;
		logic cmp;
		logic sqrt_init;
		logic sqrt_step;
		logic ramp;
		logic div_step;
		logic load_out;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic sample_go;
		logic no_keys;
		logic last_key;
		logic iter_last;
		logic ramp_direct;
	} dp_status_t;

endpackage

// ===== rtl/color_distance_falloff_sampler.sv =====
// Channel   Handshake              Payload
// in        in_valid / in_ready    in_data  (cmd, slot, rgb, u_coord, v_coord, point_rejected)
// out       out_valid / out_ready  out_data (falloff_value, sample_done)
// cfg       cfg_we                 cfg_index, cfg_data
//
// Loads, unused commands, rejected points and samples with no image go from decode to the result.
// A sample reads its pixel, then passes the key colours in use through the distance
// unit one colour per cycle, then takes a bit-serial root; a ramp that needs the
// divide adds a restoring divide before the result.
// One item is in the block at a time; the next is taken while the result waits.
// Reset clears control and configuration; image and key stores are not cleared.
module color_distance_falloff_sampler #(
	parameter int unsigned IMAGE_DEPTH = cdfs_pkg::IMAGE_DEPTH_DEF,
	parameter int unsigned MAX_COLORS  = cdfs_pkg::MAX_COLORS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  cdfs_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output cdfs_pkg::out_item_t out_data,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [7:0]          cfg_data
);

	cdfs_pkg::dp_cmd_t    cmd;
	cdfs_pkg::dp_status_t st;

	cdfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	cdfs_dp #(.IMAGE_DEPTH(IMAGE_DEPTH), .MAX_COLORS(MAX_COLORS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.st        (st)
	);

endmodule

// ===== rtl/cdfs_ram.sv =====
module cdfs_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 4096,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Single write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/cdfs_ctrl.sv =====
module cdfs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  cdfs_pkg::dp_status_t st,
	output cdfs_pkg::dp_cmd_t    cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DEC  = 4'd1;
	localparam logic [3:0] S_XY   = 4'd2;
	localparam logic [3:0] S_ADDR = 4'd3;
	localparam logic [3:0] S_RDW  = 4'd4;
	localparam logic [3:0] S_CMP  = 4'd5;
	localparam logic [3:0] S_SQRT = 4'd6;
	localparam logic [3:0] S_RAMP = 4'd7;
	localparam logic [3:0] S_DIV  = 4'd8;
	localparam logic [3:0] S_DONE = 4'd9;

	logic [3:0] state_q, state_d;
	logic       out_valid_q, out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	// Next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DEC;
				end
			end
			S_DEC: begin
				cmd.decode = 1'b1;
				state_d    = st.sample_go ? S_XY : S_DONE;
			end
			S_XY: begin
				cmd.xy  = 1'b1;
				state_d = S_ADDR;
			end
			S_ADDR: begin
				cmd.addr = 1'b1;
				state_d  = S_RDW;
			end
			S_RDW: begin
				cmd.load_pix = 1'b1;
				if (st.no_keys) begin
					cmd.sqrt_init = 1'b1;
					state_d       = S_SQRT;
				end else begin
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				cmd.cmp = 1'b1;
				if (st.last_key) begin
					cmd.sqrt_init = 1'b1;
					state_d       = S_SQRT;
				end
			end
			S_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (st.iter_last) begin
					state_d = S_RAMP;
				end
			end
			S_RAMP: begin
				cmd.ramp = 1'b1;
				state_d  = st.ramp_direct ? S_DONE : S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (st.iter_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/cdfs_dp.sv =====
module cdfs_dp #(
	parameter int unsigned IMAGE_DEPTH = cdfs_pkg::IMAGE_DEPTH_DEF,
	parameter int unsigned MAX_COLORS  = cdfs_pkg::MAX_COLORS_DEF,
	localparam int unsigned AW = (IMAGE_DEPTH > 1) ? $clog2(IMAGE_DEPTH) : 1,
	localparam int unsigned KW = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cdfs_pkg::in_item_t   in_data,
	output cdfs_pkg::out_item_t  out_data,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [7:0]           cfg_data,
	input  cdfs_pkg::dp_cmd_t    cmd,
	output cdfs_pkg::dp_status_t st
);

	// Configuration registers
	logic [6:0] width_q, height_q;
	logic [3:0] count_q;
	logic [7:0] start_q, end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= '0;
			height_q <= '0;
			count_q  <= '0;
			start_q  <= '0;
			end_q    <= 8'd255;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cdfs_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data[6:0];
				cdfs_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data[6:0];
				cdfs_pkg::REG_COLOR_COUNT:  count_q  <= cfg_data[3:0];
				cdfs_pkg::REG_START_DIST:   start_q  <= cfg_data;
				cdfs_pkg::REG_END_DIST:     end_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Item register
	cdfs_pkg::in_item_t item_q;
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= in_data;
		end
	end

	logic is_sample, trivial;
	assign is_sample = (item_q.cmd == cdfs_pkg::CMD_SAMPLE);
	assign trivial   = item_q.point_rejected || (width_q == '0) || (height_q == '0);

	// Image store
	logic          pix_we, key_we;
	logic [AW-1:0] rd_addr;
	logic [23:0]   rd_data;
	logic [14:0]   addr;

	assign pix_we = cmd.decode && (item_q.cmd == cdfs_pkg::CMD_LOAD_PIXEL)
		&& ({9'd0, item_q.slot} < 21'(IMAGE_DEPTH));
	assign key_we = cmd.decode && (item_q.cmd == cdfs_pkg::CMD_LOAD_KEY)
		&& ({9'd0, item_q.slot} < 21'(MAX_COLORS));
	assign rd_addr = AW'(addr);

	cdfs_ram #(.WIDTH(24), .DEPTH(IMAGE_DEPTH)) u_img (
		.clk   (clk),
		.we    (pix_we),
		.waddr (AW'(item_q.slot)),
		.wdata (item_q.rgb),
		.re    (cmd.addr),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// Key colour table
	logic [23:0] key_q [MAX_COLORS];
	always_ff @(posedge clk) begin
		if (key_we) begin
			key_q[KW'(item_q.slot)] <= item_q.rgb;
		end
	end

	// Wrap u,v to pixel coordinates, flip y
	logic [23:0] ux, vy;
	logic [7:0]  xr, yr;
	logic [6:0]  xw, yw;
	logic [6:0]  x_q, y_q;
	assign ux = {7'd0, item_q.u_coord} * {17'd0, width_q};
	assign vy = {7'd0, item_q.v_coord} * {17'd0, height_q};
	assign xr = ux[23:16];
	assign yr = vy[23:16];
	assign xw = (xr >= {1'b0, width_q})  ? 7'(xr - {1'b0, width_q})  : xr[6:0];
	assign yw = (yr >= {1'b0, height_q}) ? 7'(yr - {1'b0, height_q}) : yr[6:0];

	always_ff @(posedge clk) begin
		if (cmd.xy) begin
			x_q <= xw;
			y_q <= height_q - 7'd1 - yw;
		end
	end

	// Pixel address and range check
	logic oob_q;
	assign addr = ({8'd0, y_q} * {8'd0, width_q}) + {8'd0, x_q};
	always_ff @(posedge clk) begin
		if (cmd.addr) begin
			oob_q <= ({6'd0, addr} >= 21'(IMAGE_DEPTH));
		end
	end

	// Colour count saturated to table size
	logic [6:0] n_lim;
	assign n_lim = ({3'd0, count_q} > 7'(MAX_COLORS)) ? 7'(MAX_COLORS) : {3'd0, count_q};

	// One key colour per cycle, running minimum
	logic [23:0]       pix_q, key_rd;
	logic [KW-1:0]     k_q;
	logic [15:0]       minsq_q;
	logic signed [8:0] dr, dg, db;
	logic signed [17:0] pr, pg, pb;
	logic [17:0]       sq;

	assign key_rd = key_q[k_q];
	assign dr = $signed({1'b0, key_rd[23:16]}) - $signed({1'b0, pix_q[23:16]});
	assign dg = $signed({1'b0, key_rd[15:8]})  - $signed({1'b0, pix_q[15:8]});
	assign db = $signed({1'b0, key_rd[7:0]})   - $signed({1'b0, pix_q[7:0]});
	assign pr = dr * dr;
	assign pg = dg * dg;
	assign pb = db * db;
	assign sq = {2'd0, pr[15:0]} + {2'd0, pg[15:0]} + {2'd0, pb[15:0]};

	// Shared iteration counter for root and divide
	logic [3:0] cnt_q;

	// Root: one result bit per cycle
	logic [7:0]  d_q, trial;
	logic [15:0] trial_sq;
	assign trial    = d_q | (8'd1 << cnt_q[2:0]);
	assign trial_sq = trial * trial;

	// Ramp decision
	logic signed [8:0] num, den;
	logic [7:0]        an, ad;
	logic              direct;
	logic [16:0]       direct_val;
	assign num = $signed({1'b0, d_q})   - $signed({1'b0, start_q});
	assign den = $signed({1'b0, end_q}) - $signed({1'b0, start_q});
	assign an  = num[8] ? 8'(-num) : num[7:0];
	assign ad  = den[8] ? 8'(-den) : den[7:0];

	always_comb begin
		direct     = 1'b1;
		direct_val = '0;
		if (den == '0) begin
			direct_val = (d_q < start_q) ? cdfs_pkg::ONE_Q16 : '0;
		end else if ((num == '0) || (num[8] != den[8])) begin
			direct_val = cdfs_pkg::ONE_Q16;
		end else if (an >= ad) begin
			direct_val = '0;
		end else begin
			direct = 1'b0;
		end
	end

	// Restoring divide, one quotient bit per cycle
	logic [7:0]  rem_q, ad_q;
	logic [15:0] quo_q, quo_d;
	logic [8:0]  rem_sh;
	logic        qbit;
	assign rem_sh = {rem_q, 1'b0};
	assign qbit   = (rem_sh >= {1'b0, ad_q});
	assign quo_d  = {quo_q[14:0], qbit};

	logic [16:0] val_q;

	always_ff @(posedge clk) begin
		if (cmd.load_pix) begin
			pix_q   <= oob_q ? '0 : rd_data;
			k_q     <= '0;
			minsq_q <= cdfs_pkg::CEIL_SQ;
		end
		if (cmd.cmp) begin
			k_q <= k_q + KW'(1);
			if (sq < {2'd0, minsq_q}) begin
				minsq_q <= sq[15:0];
			end
		end
		if (cmd.sqrt_init) begin
			d_q   <= '0;
			cnt_q <= 4'd7;
		end
		if (cmd.sqrt_step) begin
			cnt_q <= cnt_q - 4'd1;
			if (trial_sq <= minsq_q) begin
				d_q <= trial;
			end
		end
		if (cmd.decode) begin
			val_q <= '0;
		end
		if (cmd.ramp) begin
			val_q <= direct_val;
			rem_q <= an;
			ad_q  <= ad;
			quo_q <= '0;
			cnt_q <= 4'd15;
		end
		if (cmd.div_step) begin
			cnt_q <= cnt_q - 4'd1;
			rem_q <= qbit ? 8'(rem_sh - {1'b0, ad_q}) : rem_sh[7:0];
			quo_q <= quo_d;
			if (cnt_q == '0) begin
				val_q <= cdfs_pkg::ONE_Q16 - {1'b0, quo_d};
			end
		end
		if (cmd.load_out) begin
			out_data.falloff_value <= val_q;
			out_data.sample_done   <= is_sample;
		end
	end

	// Status to controller
	assign st.sample_go   = is_sample && !trivial;
	assign st.no_keys     = (n_lim == '0);
	assign st.last_key    = ((7'(k_q) + 7'd1) == n_lim);
	assign st.iter_last   = (cnt_q == '0);
	assign st.ramp_direct = direct;

endmodule

// ===== rtl/cdfs_checker.sv =====
module cdfs_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input cdfs_pkg::out_item_t out_data,
	input logic                cfg_we
);

	// Result held until transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped or changed while stalled");

	// One item in flight: no transfer in the cycle after a transfer
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken twice in a row");

	// Loads and unused commands give zero
	a_load_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.sample_done |-> out_data.falloff_value == '0)
		else $error("non-sample result not zero");

	// Value never above one
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.falloff_value <= cdfs_pkg::ONE_Q16)
		else $error("falloff above one");

	// Configuration only written while the block is empty
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> in_ready && !out_valid)
		else $error("configuration written with an item in flight");

endmodule

bind color_distance_falloff_sampler cdfs_checker u_chk (.*);
